FILE: sv/rfr_pkg.sv
// shared types and constants for the reply frame receiver
`default_nettype none

package rfr_pkg;

  // frame bytes
  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] TERM_BYTE = 8'h0D;
  localparam logic [8:0] FRAME_OVERHEAD = 9'd8;
  localparam logic [8:0] PAYLOAD_START = 9'd6;
  localparam logic [7:0] STATION_ADDRESS_RESET = 8'h01;

  // frame byte positions of the header
  localparam logic [8:0] POS_HUNT = 9'd0;
  localparam logic [8:0] POS_ADDRESS = 9'd1;
  localparam logic [8:0] POS_FUNCTION = 9'd2;
  localparam logic [8:0] POS_REG_LOW = 9'd3;
  localparam logic [8:0] POS_REG_HIGH = 9'd4;
  localparam logic [8:0] POS_LENGTH = 9'd5;

  // result event codes
  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_ACCEPTED = 3'd1;
  localparam logic [2:0] KIND_ADDR_MISMATCH = 3'd2;
  localparam logic [2:0] KIND_CHECKSUM_ERR = 3'd3;
  localparam logic [2:0] KIND_TERM_ERR = 3'd4;
  localparam logic [2:0] KIND_TIMEOUT = 3'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timeout_event;
  } rx_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  data_byte;
    logic [7:0]  payload_index;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [7:0]  payload_length;
    logic [8:0]  frame_length;
  } result_item_t;

endpackage

`default_nettype wire

FILE: sv/rfr_tracker.sv
// frame state tracker: position, checksum, held header, result decode
`default_nettype none

module rfr_tracker
  import rfr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [7:0]   cfg_wdata,
  input  wire logic         accept,
  input  wire rx_item_t     item,
  output logic              res_valid,
  output result_item_t      res
);

  logic [7:0]  station_address;
  logic [8:0]  frame_position;
  logic [7:0]  running_sum;
  logic [7:0]  held_length;
  logic [7:0]  held_function;
  logic [15:0] held_register_address;

  logic [8:0]  frame_position_next;
  logic [7:0]  running_sum_next;
  logic [7:0]  held_length_next;
  logic [7:0]  held_function_next;
  logic [15:0] held_register_address_next;

  logic [8:0]  csum_pos;
  logic [7:0]  b;
  logic [7:0]  sum_plus_b;

  assign b = item.rx_byte;
  assign csum_pos = PAYLOAD_START + {1'b0, held_length};
  assign sum_plus_b = running_sum + b;

  // next state and result for the item at the input
  always_comb begin
    frame_position_next = frame_position;
    running_sum_next = running_sum;
    held_length_next = held_length;
    held_function_next = held_function;
    held_register_address_next = held_register_address;
    res_valid = 1'b0;
    res.event_kind = KIND_PAYLOAD;
    res.data_byte = 8'd0;
    res.payload_index = 8'd0;
    res.function_code = held_function;
    res.register_address = held_register_address;
    res.payload_length = held_length;
    res.frame_length = 9'd0;

    if (item.timeout_event) begin
      if (frame_position != POS_HUNT) begin
        frame_position_next = POS_HUNT;
        res_valid = 1'b1;
        res.event_kind = KIND_TIMEOUT;
      end
    end else if (frame_position == POS_HUNT) begin
      if (b == SYNC_BYTE) begin
        running_sum_next = SYNC_BYTE;
        held_length_next = 8'd0;
        held_function_next = 8'd0;
        held_register_address_next = 16'd0;
        frame_position_next = POS_ADDRESS;
      end
    end else if (frame_position == POS_ADDRESS) begin
      if (b != station_address) begin
        frame_position_next = POS_HUNT;
        res_valid = 1'b1;
        res.event_kind = KIND_ADDR_MISMATCH;
      end else begin
        running_sum_next = sum_plus_b;
        frame_position_next = POS_FUNCTION;
      end
    end else if (frame_position <= POS_LENGTH) begin
      // header bytes after the address
      if (frame_position == POS_FUNCTION) begin
        held_function_next = b;
      end else if (frame_position == POS_REG_LOW) begin
        held_register_address_next = {held_register_address[15:8], b};
      end else if (frame_position == POS_REG_HIGH) begin
        held_register_address_next = {b, held_register_address[7:0]};
      end else begin
        held_length_next = b;
      end
      running_sum_next = sum_plus_b;
      frame_position_next = frame_position + 9'd1;
    end else if (frame_position < csum_pos) begin
      // payload byte, streamed out tentatively
      running_sum_next = sum_plus_b;
      frame_position_next = frame_position + 9'd1;
      res_valid = 1'b1;
      res.event_kind = KIND_PAYLOAD;
      res.data_byte = b;
      res.payload_index = 8'(frame_position - PAYLOAD_START);
    end else if (frame_position == csum_pos) begin
      if (b != running_sum) begin
        frame_position_next = POS_HUNT;
        res_valid = 1'b1;
        res.event_kind = KIND_CHECKSUM_ERR;
      end else begin
        frame_position_next = frame_position + 9'd1;
      end
    end else begin
      // terminator byte ends the frame either way
      frame_position_next = POS_HUNT;
      res_valid = 1'b1;
      if (b != TERM_BYTE) begin
        res.event_kind = KIND_TERM_ERR;
      end else begin
        res.event_kind = KIND_ACCEPTED;
        res.frame_length = {1'b0, held_length} + FRAME_OVERHEAD;
      end
    end
  end

  // state registers; frame state is updated once per accepted item, the station address on cfg_we
  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= STATION_ADDRESS_RESET;
      frame_position <= POS_HUNT;
      running_sum <= 8'd0;
      held_length <= 8'd0;
      held_function <= 8'd0;
      held_register_address <= 16'd0;
    end else begin
      if (cfg_we) begin
        station_address <= cfg_wdata;
      end
      if (accept) begin
        frame_position <= frame_position_next;
        running_sum <= running_sum_next;
        held_length <= held_length_next;
        held_function <= held_function_next;
        held_register_address <= held_register_address_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/rfr_out_reg.sv
// result register stage with valid/ready handshake
`default_nettype none

module rfr_out_reg
  import rfr_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire logic          res_valid,
  input  wire result_item_t  res,
  output logic               out_valid,
  input  wire logic          out_ready,
  output result_item_t       out_data,
  output logic               free
);

  // stage can take a new item when empty or being drained
  assign free = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load && res_valid;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

FILE: sv/reply_frame_receiver.sv
// top level of the reply frame receiver
// latency: a result appears in the cycle after its input item is accepted
// throughput: one item per cycle; the result register is the only stall point
// and input ready drops only while a result waits unread
// reset: synchronous; returns to sync hunting with cleared sums and header,
// station address back to 1, result register emptied
`default_nettype none

module reply_frame_receiver
  import rfr_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_wdata,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rx_item_t      in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output result_item_t       out_data
);

  logic         accept;
  logic         res_valid;
  result_item_t res;
  logic         free;

  assign in_ready = free;
  assign accept = in_valid && free;

  // frame tracking and result decode
  rfr_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .item      (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  rfr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res_valid (res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .free      (free)
  );

endmodule

`default_nettype wire
